>>> design/belt_block_cipher_unit_macros.svh
// assertion helpers for the cipher unit, clocked on clk and held off during rst
`ifndef BELT_BLOCK_CIPHER_UNIT_MACROS_SVH
`define BELT_BLOCK_CIPHER_UNIT_MACROS_SVH

// same-cycle implication
`define BBC_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define BBC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> design/bbc_pkg.sv
package bbc_pkg;

  localparam int Rounds   = 8;
  localparam int Steps    = 7;
  localparam int NumCells = Rounds * Steps;
  localparam int KeyWords = 8;
  localparam int KeyIdxW  = 4;
  localparam int RndW     = 4;

  localparam logic REQ_ENC = 1'b0;
  localparam logic REQ_DEC = 1'b1;

  // one G step of a round; the name gives the target word and the operand
  typedef enum logic [2:0] {
    STEP_B_FROM_A   = 3'd0,
    STEP_C_FROM_D   = 3'd1,
    STEP_A_FROM_B   = 3'd2,
    STEP_MIX_BC     = 3'd3,
    STEP_D_FROM_C   = 3'd4,
    STEP_B_FROM_A_2 = 3'd5,
    STEP_C_FROM_D_2 = 3'd6
  } step_t;

  typedef struct packed {
    logic        vld;
    logic        dec;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } belt_word_t;

  localparam logic [7:0] HTAB [0:255] = '{
    8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
    8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
    8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
    8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
    8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
    8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
    8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
    8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
    8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
    8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
    8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
    8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
    8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
    8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
    8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
    8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
  };

  function automatic logic [31:0] sub_bytes(input logic [31:0] x);
    logic [31:0] s;
    for (int n = 0; n < 4; n++) begin
      s[8*n +: 8] = HTAB[x[8*n +: 8]];
    end
    return s;
  endfunction

endpackage

>>> design/bbc_cell.sv
module bbc_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  bbc_pkg::step_t     step,
  input  logic [31:0]        key_enc,
  input  logic [31:0]        key_dec,
  input  logic [bbc_pkg::RndW-1:0] rnd_enc,
  input  logic [bbc_pkg::RndW-1:0] rnd_dec,
  input  bbc_pkg::belt_word_t din,
  output bbc_pkg::belt_word_t dout
);

  logic [31:0]         key;
  logic [bbc_pkg::RndW-1:0] rnd;
  logic [31:0]         x;
  logic [31:0]         s;
  logic [31:0]         g;
  logic [31:0]         e;
  logic [31:0]         c_new;
  bbc_pkg::belt_word_t nxt;

  always_comb begin
    key = (din.dec == bbc_pkg::REQ_DEC) ? key_dec : key_enc;
    rnd = (din.dec == bbc_pkg::REQ_DEC) ? rnd_dec : rnd_enc;

    unique case (step)
      bbc_pkg::STEP_B_FROM_A,
      bbc_pkg::STEP_B_FROM_A_2: x = din.a + key;
      bbc_pkg::STEP_C_FROM_D,
      bbc_pkg::STEP_C_FROM_D_2: x = din.d + key;
      bbc_pkg::STEP_A_FROM_B:   x = din.b + key;
      bbc_pkg::STEP_MIX_BC:     x = din.b + din.c + key;
      bbc_pkg::STEP_D_FROM_C:   x = din.c + key;
      default:                  x = din.a + key;
    endcase

    s = bbc_pkg::sub_bytes(x);

    unique case (step)
      bbc_pkg::STEP_B_FROM_A,
      bbc_pkg::STEP_C_FROM_D_2: g = {s[26:0], s[31:27]};
      bbc_pkg::STEP_A_FROM_B,
      bbc_pkg::STEP_D_FROM_C:   g = {s[18:0], s[31:19]};
      default:                  g = {s[10:0], s[31:11]};
    endcase

    e     = g ^ {{(32-bbc_pkg::RndW){1'b0}}, rnd};
    c_new = din.c ^ g;

    nxt = din;
    unique case (step)
      bbc_pkg::STEP_B_FROM_A,
      bbc_pkg::STEP_B_FROM_A_2: nxt.b = din.b ^ g;
      bbc_pkg::STEP_C_FROM_D:   nxt.c = din.c ^ g;
      bbc_pkg::STEP_A_FROM_B:   nxt.a = din.a - g;
      bbc_pkg::STEP_MIX_BC: begin
        nxt.b = din.b + e;
        nxt.c = din.c - e;
      end
      bbc_pkg::STEP_D_FROM_C:   nxt.d = din.d + g;
      bbc_pkg::STEP_C_FROM_D_2: begin
        // last step of the round, word shuffle differs by direction
        if (din.dec == bbc_pkg::REQ_DEC) begin
          nxt.a = c_new;
          nxt.b = din.a;
          nxt.c = din.d;
          nxt.d = din.b;
        end else begin
          nxt.a = din.b;
          nxt.b = din.d;
          nxt.c = din.a;
          nxt.d = c_new;
        end
      end
      default: nxt = din;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

>>> design/belt_block_cipher_unit.sv
// channel | direction | handshake              | payload
// in      | into      | in_valid / in_ready    | req_type, block_lo, block_hi
// out     | out of    | out_valid / out_ready  | result_lo, result_hi
// cfg     | into      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one block per cycle while the skid slot is empty; a row of 56 cells does one G
// step each, and a block passes through every cell register in turn to the output register.
// the output register has a one-word skid slot; while it is full the row holds
// and in_ready is low. cfg_ready is always high.
// rst clears the key words to zero and empties the row and the output stage.
`include "belt_block_cipher_unit_macros.svh"

module belt_block_cipher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [63:0] block_lo,
  input  logic [63:0] block_hi,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_lo,
  output logic [63:0] result_hi,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bbc_pkg::KeyIdxW-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] key [bbc_pkg::KeyWords];

  bbc_pkg::belt_word_t in_word;
  bbc_pkg::belt_word_t stg [bbc_pkg::NumCells];
  bbc_pkg::belt_word_t last;

  logic        pipe_en;
  logic        deliver;
  logic        out_take;
  logic        skid_full;
  logic [63:0] skid_lo;
  logic [63:0] skid_hi;
  logic [63:0] fin_lo;
  logic [63:0] fin_hi;
  logic [bbc_pkg::NumCells-1:0] stg_vld;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < bbc_pkg::KeyWords; n++) begin
        key[n] <= '0;
      end
    end else if (cfg_valid && (cfg_index < bbc_pkg::KeyIdxW'(bbc_pkg::KeyWords))) begin
      key[cfg_index[2:0]] <= cfg_data;
    end
  end

  assign pipe_en  = !skid_full;
  assign in_ready = pipe_en;

  always_comb begin
    in_word.vld = in_valid;
    in_word.dec = req_type;
    in_word.a   = block_lo[31:0];
    in_word.b   = block_lo[63:32];
    in_word.c   = block_hi[31:0];
    in_word.d   = block_hi[63:32];
  end

  for (genvar g = 0; g < bbc_pkg::NumCells; g++) begin : g_cell
    localparam int Rnd = g / bbc_pkg::Steps;
    localparam int Stp = g % bbc_pkg::Steps;
    localparam int Ke  = (bbc_pkg::Steps * Rnd + Stp) % bbc_pkg::KeyWords;
    localparam int Kd  = (bbc_pkg::NumCells - 1 - bbc_pkg::Steps * Rnd - Stp)
                         % bbc_pkg::KeyWords;

    bbc_pkg::belt_word_t cin;

    if (g == 0) begin : g_head
      assign cin = in_word;
    end else begin : g_link
      assign cin = stg[g-1];
    end

    bbc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (pipe_en),
      .step    (bbc_pkg::step_t'(3'(Stp))),
      .key_enc (key[Ke]),
      .key_dec (key[Kd]),
      .rnd_enc (bbc_pkg::RndW'(Rnd + 1)),
      .rnd_dec (bbc_pkg::RndW'(bbc_pkg::Rounds - Rnd)),
      .din     (cin),
      .dout    (stg[g])
    );

    assign stg_vld[g] = stg[g].vld;
  end

  assign last     = stg[bbc_pkg::NumCells-1];
  assign deliver  = pipe_en && last.vld;
  assign out_take = out_valid && out_ready;

  // final word order differs by direction
  always_comb begin
    if (last.dec == bbc_pkg::REQ_DEC) begin
      fin_lo = {last.a, last.c};
      fin_hi = {last.b, last.d};
    end else begin
      fin_lo = {last.d, last.b};
      fin_hi = {last.c, last.a};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_take) begin
        skid_full <= 1'b0;
      end
    end else if (deliver) begin
      if (out_valid && !out_ready) begin
        skid_full <= 1'b1;
      end
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_take) begin
        result_lo <= skid_lo;
        result_hi <= skid_hi;
      end
    end else if (deliver) begin
      if (!out_valid || out_ready) begin
        result_lo <= fin_lo;
        result_hi <= fin_hi;
      end else begin
        skid_lo <= fin_lo;
        skid_hi <= fin_hi;
      end
    end
  end

  `BBC_ASSERT_IMP(a_skid_behind_out, skid_full, out_valid, "skid word without output word")
  `BBC_ASSERT_NEXT(a_row_holds, !pipe_en, $stable(stg_vld), "cell row moved while held")
  `BBC_ASSERT_NEXT(a_stall_to_skid, deliver && out_valid && !out_ready, skid_full,
                   "word leaving the row was not parked")

endmodule

>>> test/tb_belt_block_cipher_unit.sv
`timescale 1ns / 100ps

module tb_belt_block_cipher_unit;

  localparam int LATENCY = 56;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int KEY_SETTINGS = 5;
  localparam int BLOCKS_PER_SETTING = 190;
  localparam int MAX_REPORTS = 10;
  localparam logic [bbc_pkg::KeyIdxW-1:0] KEY_WORD_0 = '0;
  localparam logic [bbc_pkg::KeyIdxW-1:0] UNUSED_INDEX_FIRST =
    bbc_pkg::KeyIdxW'(bbc_pkg::KeyWords);

  typedef struct {
    logic        dec;
    logic [63:0] lo;
    logic [63:0] hi;
  } cipher_req_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } cipher_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = bbc_pkg::REQ_ENC;
  logic [63:0] block_lo = '0;
  logic [63:0] block_hi = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] result_lo;
  logic [63:0] result_hi;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bbc_pkg::KeyIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [31:0] key_copy [bbc_pkg::KeyWords];
  logic [31:0] key_plan [bbc_pkg::KeyWords];
  cipher_req_t blocks_to_send[$];
  cipher_out_t ciphertexts_due[$];

  int blocks_queued = 0;
  int results_seen = 0;
  int fails = 0;
  int enc_blocks = 0;
  int dec_blocks = 0;
  int key_writes = 0;
  int ignored_writes = 0;
  int key_settings_run = 0;
  int in_stall_cycles = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int quiet = 0;
  logic calm = 1'b0;

  belt_block_cipher_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .block_lo  (block_lo),
    .block_hi  (block_hi),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_lo (result_lo),
    .result_hi (result_hi),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // byte substitution through the h table, then rotate left by r
  function automatic logic [31:0] g_rot(input logic [31:0] x, input int r);
    logic [31:0] s;
    for (int n = 0; n < 4; n++) begin
      s[8*n +: 8] = bbc_pkg::HTAB[x[8*n +: 8]];
    end
    return (s << r) | (s >> (32 - r));
  endfunction

  function automatic logic [31:0] round_key(input int j);
    return key_copy[3'((j - 1) % bbc_pkg::KeyWords)];
  endfunction

  function automatic cipher_out_t belt_transform(input cipher_req_t q);
    logic [31:0] a, b, c, d, e, t;
    cipher_out_t r;
    a = q.lo[31:0];
    b = q.lo[63:32];
    c = q.hi[31:0];
    d = q.hi[63:32];
    if (q.dec == bbc_pkg::REQ_ENC) begin
      for (int i = 1; i <= bbc_pkg::Rounds; i++) begin
        b ^= g_rot(a + round_key(7*i - 6), 5);
        c ^= g_rot(d + round_key(7*i - 5), 21);
        a -= g_rot(b + round_key(7*i - 4), 13);
        e = g_rot(b + c + round_key(7*i - 3), 21) ^ 32'(i);
        b += e;
        c -= e;
        d += g_rot(c + round_key(7*i - 2), 13);
        b ^= g_rot(a + round_key(7*i - 1), 21);
        c ^= g_rot(d + round_key(7*i), 5);
        t = a; a = b; b = t;
        t = c; c = d; d = t;
        t = b; b = c; c = t;
      end
      r.lo = {d, b};
      r.hi = {c, a};
    end else begin
      for (int i = bbc_pkg::Rounds; i >= 1; i--) begin
        b ^= g_rot(a + round_key(7*i), 5);
        c ^= g_rot(d + round_key(7*i - 1), 21);
        a -= g_rot(b + round_key(7*i - 2), 13);
        e = g_rot(b + c + round_key(7*i - 3), 21) ^ 32'(i);
        b += e;
        c -= e;
        d += g_rot(c + round_key(7*i - 4), 13);
        b ^= g_rot(a + round_key(7*i - 5), 21);
        c ^= g_rot(d + round_key(7*i - 6), 5);
        t = a; a = b; b = t;
        t = c; c = d; d = t;
        t = a; a = d; d = t;
      end
      r.lo = {a, c};
      r.hi = {b, d};
    end
    return r;
  endfunction

  // mostly random, with the all-zero and all-one words mixed in
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(7))
      0: w = 32'h0000_0000;
      1: w = 32'hFFFF_FFFF;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic queue_block(input logic dec, input logic [63:0] lo, input logic [63:0] hi);
    cipher_req_t q;
    q.dec = dec;
    q.lo = lo;
    q.hi = hi;
    blocks_to_send.push_back(q);
    blocks_queued++;
  endtask

  // called right after a rising edge; returns at the edge that took the word
  task automatic cfg_write(input logic [bbc_pkg::KeyIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    key_writes++;
    if (idx < bbc_pkg::KeyWords) begin
      key_copy[idx[2:0]] = data;
    end else begin
      ignored_writes++;
    end
  endtask

  task automatic load_key_plan();
    // writes to unused indexes must leave the key alone
    cfg_write(UNUSED_INDEX_FIRST +
              bbc_pkg::KeyIdxW'($urandom_range(bbc_pkg::KeyWords - 1)), $urandom);
    for (int n = 0; n < bbc_pkg::KeyWords; n++) begin
      cfg_write(KEY_WORD_0 + bbc_pkg::KeyIdxW'(n), key_plan[n]);
    end
    cfg_write(UNUSED_INDEX_FIRST +
              bbc_pkg::KeyIdxW'($urandom_range(bbc_pkg::KeyWords - 1)), $urandom);
    cfg_valid <= 1'b0;
    key_settings_run++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (results_seen < blocks_queued) @(posedge clk);
  endtask

  // driver: a new word goes out once the previous one is taken
  always @(posedge clk) begin : drive
    cipher_req_t cur;
    cipher_req_t nxt;
    logic take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = !in_valid;
      if (in_valid && in_ready) begin
        cur.dec = req_type;
        cur.lo = block_lo;
        cur.hi = block_hi;
        ciphertexts_due.push_back(belt_transform(cur));
        if (req_type == bbc_pkg::REQ_DEC) dec_blocks++;
        else enc_blocks++;
        take = 1'b1;
      end else if (in_valid) begin
        in_stall_cycles++;
      end
      if (take) begin
        if (blocks_to_send.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
          nxt = blocks_to_send.pop_front();
          in_valid <= 1'b1;
          req_type <= nxt.dec;
          block_lo <= nxt.lo;
          block_hi <= nxt.hi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    cipher_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (ciphertexts_due.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("result with no block outstanding: lo %h hi %h", result_lo, result_hi);
        end else begin
          want = ciphertexts_due.pop_front();
          if (result_lo !== want.lo || result_hi !== want.hi) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("block %0d: result_lo exp %h got %h, result_hi exp %h got %h",
                       results_seen, want.lo, result_lo, want.hi, result_hi);
          end
        end
      end
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || $urandom_range(99) >= 8;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("no word moved for %0d cycles", STALL_LIMIT);
        $display("belt_block_cipher_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    for (int n = 0; n < bbc_pkg::KeyWords; n++) key_copy[n] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // key never written: engine must run with the all-zero key
    queue_block(bbc_pkg::REQ_ENC, 64'h0, 64'h0);
    queue_block(bbc_pkg::REQ_DEC, 64'h0, 64'h0);
    queue_block(bbc_pkg::REQ_ENC, '1, '1);
    queue_block(bbc_pkg::REQ_DEC, '1, '1);
    wait_drained();

    key_plan = '{32'h2CE7DEE9, 32'hA60F0C8F, 32'hF449DB2D, 32'h4796736F,
                 32'h16530706, 32'h377A24ED, 32'h83A3CB39, 32'hF68BA903};
    load_key_plan();
    queue_block(bbc_pkg::REQ_ENC, 64'h3BF5080AC8BA94B1, 64'hE45D4A588E006D36);
    queue_block(bbc_pkg::REQ_DEC, 64'hE3C95735C9A1CC69, 64'h6EFA88FAE0C36BD6);
    queue_block(bbc_pkg::REQ_ENC, 64'h0, 64'h0);
    queue_block(bbc_pkg::REQ_DEC, 64'h0, 64'h0);
    queue_block(bbc_pkg::REQ_ENC, '1, '1);
    queue_block(bbc_pkg::REQ_DEC, '1, '1);
    queue_block(bbc_pkg::REQ_ENC, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_block(bbc_pkg::REQ_DEC, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    queue_block(bbc_pkg::REQ_ENC, '1, 64'h0);
    queue_block(bbc_pkg::REQ_DEC, 64'h0, '1);
    queue_block(bbc_pkg::REQ_ENC, 64'h1, 64'h0);
    queue_block(bbc_pkg::REQ_ENC, 64'h0, 64'h8000_0000_0000_0000);
    queue_block(bbc_pkg::REQ_DEC, 64'h8000_0000_0000_0000, 64'h0);
    queue_block(bbc_pkg::REQ_DEC, 64'h0, 64'h1);
    wait_drained();

    for (int p = 0; p < KEY_SETTINGS; p++) begin
      for (int n = 0; n < bbc_pkg::KeyWords; n++) begin
        case (p)
          0: key_plan[n] = 32'h0000_0000;
          1: key_plan[n] = 32'hFFFF_FFFF;
          4: key_plan[n] = rand_word();
          default: key_plan[n] = $urandom;
        endcase
      end
      load_key_plan();
      calm = (p == 3);
      for (int k = 0; k < BLOCKS_PER_SETTING; k++) begin
        queue_block(1'($urandom_range(1)), {rand_word(), rand_word()},
                    {rand_word(), rand_word()});
      end
      // long receiver hold-off while the sender keeps offering, so the row fills
      if (p == 2) hold_asked++;
      wait_drained();
      calm = 1'b0;
    end

    repeat (LATENCY + 8) @(posedge clk);
    if (ciphertexts_due.size() != 0) begin
      $display("%0d results never arrived", ciphertexts_due.size());
      fails += ciphertexts_due.size();
    end
    $display("covered %0d blocks (%0d encrypt, %0d decrypt) under %0d written key settings",
             enc_blocks + dec_blocks, enc_blocks, dec_blocks, key_settings_run);
    $display("%0d key register writes, %0d to unused indexes; input stalled %0d cycles",
             key_writes, ignored_writes, in_stall_cycles);
    if (fails == 0) begin
      $display("belt_block_cipher_unit regression: pass");
    end else begin
      $display("%0d failures", fails);
      $display("belt_block_cipher_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/bbc_pkg.sv
design/bbc_cell.sv
design/belt_block_cipher_unit.sv
test/tb_belt_block_cipher_unit.sv
